@@ rtl/core/e2r_pkg.sv @@
// Package for the Euler-angle to rotation-matrix unit.
// Holds the CORDIC constants, format widths and shared types; no dependencies.
package e2r_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int IN_W     = 16;
    localparam int CELL_W   = FRACTION_BITS_DEF + 2;
    localparam int STAGES   = 30;
    localparam int CW       = 34;   // CORDIC x/y datapath width (Q1.30 plus growth)
    localparam int ZW       = 33;   // phase residue width
    localparam int PW       = 63;   // Q2.60 product / sum width
    localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_Q30      = CW'(64'sd1 << 30);

    function automatic logic signed [ZW-1:0] arc_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
           12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
           15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
           18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
           21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
           24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
           27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
           default: t = 32'h0;
        endcase
        return signed'({1'b0, t});
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic signed [IN_W-1:0] yaw_angle;
        logic signed [IN_W-1:0] pitch_angle;
        logic signed [IN_W-1:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_00;
        logic signed [CELL_W-1:0] cell_01;
        logic signed [CELL_W-1:0] cell_02;
        logic signed [CELL_W-1:0] cell_10;
        logic signed [CELL_W-1:0] cell_11;
        logic signed [CELL_W-1:0] cell_12;
        logic signed [CELL_W-1:0] cell_20;
        logic signed [CELL_W-1:0] cell_21;
        logic signed [CELL_W-1:0] cell_22;
    } t_matrix;
endpackage

@@ rtl/core/e2r_stream_if.sv @@
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing; payload type given by the user.
interface e2r_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/e2r_cordic.sv @@
// Pipelined rotation-mode CORDIC: one angle in per cycle while i_en is high, sine and cosine out.
// Depends on e2r_pkg.
module e2r_cordic #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [e2r_pkg::IN_W-1:0]           i_angle,
    output logic signed [e2r_pkg::CW-1:0]      o_sin,
    output logic signed [e2r_pkg::CW-1:0]      o_cos
);
    import e2r_pkg::*;

    t_rot r_st [0:STAGES];
    logic [31:0] phase;
    logic [1:0]  quad;
    logic        flip;

    always_comb begin
        phase = {i_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        quad  = phase[31:30];
        flip  = (quad == 2'd1) || (quad == 2'd2);
        if (flip) begin
            phase = phase + 32'h80000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].x    <= CORDIC_START;
            r_st[0].y    <= '0;
            r_st[0].z    <= ZW'(signed'(phase));
            r_st[0].flip <= flip;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g+1].flip <= r_st[g].flip;
                if (!r_st[g].z[ZW-1]) begin
                    r_st[g+1].x <= r_st[g].x - (r_st[g].y >>> g);
                    r_st[g+1].y <= r_st[g].y + (r_st[g].x >>> g);
                    r_st[g+1].z <= r_st[g].z - arc_turn(g);
                end else begin
                    r_st[g+1].x <= r_st[g].x + (r_st[g].y >>> g);
                    r_st[g+1].y <= r_st[g].y - (r_st[g].x >>> g);
                    r_st[g+1].z <= r_st[g].z + arc_turn(g);
                end
            end
        end
    end

    logic signed [CW-1:0] fx, fy;
    always_comb begin
        fx = r_st[STAGES].flip ? -r_st[STAGES].x : r_st[STAGES].x;
        fy = r_st[STAGES].flip ? -r_st[STAGES].y : r_st[STAGES].y;
        o_cos = (fx > ONE_Q30) ? ONE_Q30 : (fx < -ONE_Q30) ? -ONE_Q30 : fx;
        o_sin = (fy > ONE_Q30) ? ONE_Q30 : (fy < -ONE_Q30) ? -ONE_Q30 : fy;
    end
endmodule

@@ rtl/core/e2r_matrix.sv @@
// Product and sum stages that form the nine matrix cells from sines and cosines.
// Depends on e2r_pkg.
module e2r_matrix #(
    parameter int FRACTION_BITS = e2r_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [e2r_pkg::CW-1:0]      i_sy, i_cy, i_sp, i_cp, i_sr, i_cr,
    output logic [9*(FRACTION_BITS+2)-1:0]     o_cells
);
    import e2r_pkg::*;
    localparam int OW = FRACTION_BITS + 2;
    localparam int SH = 60 - FRACTION_BITS;

    // stage A: register the clamped sines/cosines
    logic signed [31:0] r_sy, r_cy, r_sp, r_cp, r_sr, r_cr;
    // stage B: pair products
    logic signed [PW-1:0] r_spsr, r_spcr, r_cycp, r_sycp, r_cpsr, r_cpcr;
    logic signed [PW-1:0] r_sysr, r_sycr, r_cysr, r_cycr;
    logic signed [31:0]   r_sy2, r_cy2, r_sp2;
    // stage C: rounded inner pairs
    logic signed [31:0]   r_qsr, r_qcr;
    logic signed [PW-1:0] r_cycp3, r_sycp3, r_cpsr3, r_cpcr3, r_sysr3, r_sycr3;
    logic signed [PW-1:0] r_cysr3, r_cycr3;
    logic signed [31:0]   r_sy3, r_cy3, r_sp3;
    // stage D: triple products
    logic signed [PW-1:0] r_t1, r_t2, r_t4, r_t5;
    logic signed [PW-1:0] r_cycp4, r_sycp4, r_cpsr4, r_cpcr4, r_sysr4, r_sycr4;
    logic signed [PW-1:0] r_cysr4, r_cycr4, r_sp4;
    // stage E: sums
    logic signed [PW:0]   r_sum [0:8];
    // stage F: output
    logic [OW-1:0]        r_out [0:8];

    function automatic logic [OW-1:0] to_field(input logic signed [PW:0] v);
        logic signed [PW:0] r;
        logic signed [PW:0] lim;
        r   = (v + ((PW+1)'(1) <<< (SH-1))) >>> SH;
        lim = (PW+1)'(1) <<< FRACTION_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[OW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sy <= 32'(i_sy); r_cy <= 32'(i_cy); r_sp <= 32'(i_sp);
            r_cp <= 32'(i_cp); r_sr <= 32'(i_sr); r_cr <= 32'(i_cr);

            r_spsr <= PW'(r_sp * r_sr); r_spcr <= PW'(r_sp * r_cr);
            r_cycp <= PW'(r_cy * r_cp); r_sycp <= PW'(r_sy * r_cp);
            r_cpsr <= PW'(r_cp * r_sr); r_cpcr <= PW'(r_cp * r_cr);
            r_sysr <= PW'(r_sy * r_sr); r_sycr <= PW'(r_sy * r_cr);
            r_cysr <= PW'(r_cy * r_sr); r_cycr <= PW'(r_cy * r_cr);
            r_sy2 <= r_sy; r_cy2 <= r_cy; r_sp2 <= r_sp;

            r_qsr <= 32'((r_spsr + (PW'(1) <<< 29)) >>> 30);
            r_qcr <= 32'((r_spcr + (PW'(1) <<< 29)) >>> 30);
            r_cycp3 <= r_cycp; r_sycp3 <= r_sycp; r_cpsr3 <= r_cpsr; r_cpcr3 <= r_cpcr;
            r_sysr3 <= r_sysr; r_sycr3 <= r_sycr; r_cysr3 <= r_cysr; r_cycr3 <= r_cycr;
            r_sy3 <= r_sy2; r_cy3 <= r_cy2; r_sp3 <= r_sp2;

            r_t1 <= PW'(r_qsr * r_cy3); r_t2 <= PW'(r_qcr * r_cy3);
            r_t4 <= PW'(r_qsr * r_sy3); r_t5 <= PW'(r_qcr * r_sy3);
            r_cycp4 <= r_cycp3; r_sycp4 <= r_sycp3; r_cpsr4 <= r_cpsr3;
            r_cpcr4 <= r_cpcr3; r_sysr4 <= r_sysr3; r_sycr4 <= r_sycr3;
            r_cysr4 <= r_cysr3; r_cycr4 <= r_cycr3;
            r_sp4 <= PW'(r_sp3) <<< 30;

            r_sum[0] <= (PW+1)'(r_cycp4);
            r_sum[1] <= (PW+1)'(r_sycr4) - (PW+1)'(r_t1);
            r_sum[2] <= (PW+1)'(r_t2) + (PW+1)'(r_sysr4);
            r_sum[3] <= -(PW+1)'(r_sycp4);
            r_sum[4] <= (PW+1)'(r_t4) + (PW+1)'(r_cycr4);
            r_sum[5] <= (PW+1)'(r_cysr4) - (PW+1)'(r_t5);
            r_sum[6] <= -(PW+1)'(r_sp4);
            r_sum[7] <= -(PW+1)'(r_cpsr4);
            r_sum[8] <= (PW+1)'(r_cpcr4);

            for (int k = 0; k < 9; k++) begin
                r_out[k] <= to_field(r_sum[k]);
            end
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_out
        assign o_cells[k*OW +: OW] = r_out[k];
    end
endmodule

@@ rtl/core/euler_to_rotation_matrix_unit.sv @@
// Euler angles (yaw, pitch, roll) to 3x3 rotation matrix, Q1.14 by default.
// Pipeline: 37 register stages (31 CORDIC, 6 matrix). Throughput: one item per
// cycle; the whole pipe advances
// together and holds when the output register is full and not taken.
// Reset: synchronous active-low i_rst_n clears the stage valid bits only.
// Depends on e2r_pkg, e2r_stream_if, e2r_cordic and e2r_matrix.
module euler_to_rotation_matrix_unit #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    e2r_stream_if.sink   i_in,
    e2r_stream_if.source o_out
);
    import e2r_pkg::*;
    localparam int LAT = STAGES + 1 + 6;
    localparam int OW  = CELL_W;

    // Valid bits travel with the data; the pipe advances when the last
    // stage is empty or is being taken.
    logic [LAT-1:0] r_vld;
    logic           adv;
    assign adv         = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    logic signed [CW-1:0] sy, cy, sp, cp, sr, cr;

    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_in.data.yaw_angle),
        .o_sin(sy), .o_cos(cy));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_in.data.pitch_angle),
        .o_sin(sp), .o_cos(cp));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_in.data.roll_angle),
        .o_sin(sr), .o_cos(cr));

    logic [9*OW-1:0] cells;
    e2r_matrix #(.FRACTION_BITS(FRACTION_BITS_DEF)) u_matrix (
        .i_clk(i_clk), .i_en(adv),
        .i_sy(sy), .i_cy(cy), .i_sp(sp), .i_cp(cp), .i_sr(sr), .i_cr(cr),
        .o_cells(cells));

    assign o_out.data.cell_00 = cells[0*OW +: OW];
    assign o_out.data.cell_01 = cells[1*OW +: OW];
    assign o_out.data.cell_02 = cells[2*OW +: OW];
    assign o_out.data.cell_10 = cells[3*OW +: OW];
    assign o_out.data.cell_11 = cells[4*OW +: OW];
    assign o_out.data.cell_12 = cells[5*OW +: OW];
    assign o_out.data.cell_20 = cells[6*OW +: OW];
    assign o_out.data.cell_21 = cells[7*OW +: OW];
    assign o_out.data.cell_22 = cells[8*OW +: OW];
endmodule

@@ bench/euler_to_rotation_matrix_unit_test.sv @@
// Self-checking bench for euler_to_rotation_matrix_unit: streams angle triples,
// predicts each 3x3 matrix with a CORDIC model and checks every output transfer.
// Depends on e2r_pkg, e2r_stream_if and the unit itself.
module euler_to_rotation_matrix_unit_test;
    import e2r_pkg::*;

    localparam int ROUND_SHIFT = 60 - FRACTION_BITS_DEF;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam longint ATAN_TURNS [STAGES] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic i_clk;
    logic i_rst_n;

    e2r_stream_if #(.T(t_angles)) angle_if  (i_clk);
    e2r_stream_if #(.T(t_matrix)) matrix_if (i_clk);

    euler_to_rotation_matrix_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (angle_if),
        .o_out   (matrix_if)
    );

    t_angles pending_angles [$];
    t_matrix expected_matrices [$];
    int      error_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      send_hold;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint clamp_unit(input longint v);
        longint one;
        one = longint'(1) << 30;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    // Rotation-mode CORDIC on a binary angle; returns Q1.30 sine and cosine.
    task automatic cordic_sin_cos(input logic [IN_W-1:0] angle,
                                  output longint sin_q30, output longint cos_q30);
        logic [31:0] phase;
        bit          flip;
        longint      x, y, z, nx, ny;
        phase = {angle, 16'b0};
        // Fold the left half plane onto the right and negate afterward.
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip)
            phase = phase + 32'h8000_0000;
        z = longint'($signed(phase));
        x = longint'(CORDIC_START);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q30 = clamp_unit(x);
        sin_q30 = clamp_unit(y);
    endtask

    // Q2.60 to a saturated Q1.14 cell.
    function automatic logic signed [15:0] q60_to_cell(input longint v);
        longint r;
        longint lim;
        lim = longint'(1) << FRACTION_BITS_DEF;
        r = (v + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

    task automatic predict_matrix(input t_angles a, output t_matrix m);
        longint sy, cy, sp, cp, sr, cr, spsr, spcr;
        cordic_sin_cos(a.yaw_angle,   sy, cy);
        cordic_sin_cos(a.pitch_angle, sp, cp);
        cordic_sin_cos(a.roll_angle,  sr, cr);
        // Inner pairs of the triple products round back to Q1.30 first.
        spsr = (sp * sr + (longint'(1) << 29)) >>> 30;
        spcr = (sp * cr + (longint'(1) << 29)) >>> 30;
        m.cell_00 = q60_to_cell(cy * cp);
        m.cell_01 = q60_to_cell(sy * cr - spsr * cy);
        m.cell_02 = q60_to_cell(spcr * cy + sy * sr);
        m.cell_10 = q60_to_cell(-(sy * cp));
        m.cell_11 = q60_to_cell(spsr * sy + cy * cr);
        m.cell_12 = q60_to_cell(cy * sr - spcr * sy);
        m.cell_20 = q60_to_cell(-(sp <<< 30));
        m.cell_21 = q60_to_cell(-(cp * sr));
        m.cell_22 = q60_to_cell(cp * cr);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: predict on each accepted transfer, then refill the slot or idle.
    always @(posedge i_clk) begin
        t_matrix m;
        if (!i_rst_n) begin
            angle_if.valid <= 1'b0;
        end else begin
            if (angle_if.valid && angle_if.ready) begin
                predict_matrix(angle_if.data, m);
                expected_matrices.push_back(m);
            end
            if (!angle_if.valid || angle_if.ready) begin
                if (pending_angles.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    angle_if.data  <= pending_angles.pop_front();
                    angle_if.valid <= 1'b1;
                end else begin
                    angle_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_matrix want;
        t_matrix got;
        if (!i_rst_n) begin
            matrix_if.ready <= 1'b0;
        end else begin
            if (matrix_if.valid && matrix_if.ready) begin
                got = matrix_if.data;
                if (expected_matrices.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = expected_matrices.pop_front();
                    if (got.cell_00 !== want.cell_00)
                        report_mismatch("cell_00", got.cell_00, want.cell_00);
                    if (got.cell_01 !== want.cell_01)
                        report_mismatch("cell_01", got.cell_01, want.cell_01);
                    if (got.cell_02 !== want.cell_02)
                        report_mismatch("cell_02", got.cell_02, want.cell_02);
                    if (got.cell_10 !== want.cell_10)
                        report_mismatch("cell_10", got.cell_10, want.cell_10);
                    if (got.cell_11 !== want.cell_11)
                        report_mismatch("cell_11", got.cell_11, want.cell_11);
                    if (got.cell_12 !== want.cell_12)
                        report_mismatch("cell_12", got.cell_12, want.cell_12);
                    if (got.cell_20 !== want.cell_20)
                        report_mismatch("cell_20", got.cell_20, want.cell_20);
                    if (got.cell_21 !== want.cell_21)
                        report_mismatch("cell_21", got.cell_21, want.cell_21);
                    if (got.cell_22 !== want.cell_22)
                        report_mismatch("cell_22", got.cell_22, want.cell_22);
                end
            end
            matrix_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Random angle: mostly uniform, sometimes on or next to a quarter turn.
    function automatic logic [IN_W-1:0] random_angle();
        logic [IN_W-1:0] a;
        a = IN_W'($urandom);
        if ($urandom_range(3) == 0)
            a = {a[15:14], 14'b0} + IN_W'($signed($urandom_range(4)) - 2);
        return a;
    endfunction

    task automatic queue_random(input int count);
        t_angles a;
        for (int i = 0; i < count; i++) begin
            a.yaw_angle   = random_angle();
            a.pitch_angle = random_angle();
            a.roll_angle  = random_angle();
            pending_angles.push_back(a);
        end
    endtask

    task automatic wait_drained();
        while (pending_angles.size() > 0 || angle_if.valid)
            @(posedge i_clk);
    endtask

    initial begin
        logic [IN_W-1:0] corners [8];
        t_angles a;
        error_count    = 0;
        send_hold      = 1'b0;
        send_idle_pct  = 25;
        recv_idle_pct  = 45;
        i_rst_n        = 1'b0;
        angle_if.valid = 1'b0;
        angle_if.data  = '0;
        matrix_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, quarter, half turns and the field extremes.
        corners = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                    16'h7FFF, 16'h2000, 16'h0001, 16'hFFFF};
        for (int i = 0; i < 8; i++) begin
            a.yaw_angle   = corners[i];
            a.pitch_angle = corners[(i + 3) % 8];
            a.roll_angle  = corners[(i + 5) % 8];
            pending_angles.push_back(a);
            a = '{corners[i], corners[i], corners[i]};
            pending_angles.push_back(a);
        end
        // Gimbal lock: pitch at plus and minus a quarter turn.
        a = '{16'h1234, 16'h4000, 16'h5678};
        pending_angles.push_back(a);
        a = '{16'hA5A5, 16'hC000, 16'h5A5A};
        pending_angles.push_back(a);
        queue_random(200);
        wait_drained();

        // Hold off the sender until the pipe has emptied completely.
        send_hold = 1'b1;
        while (expected_matrices.size() > 0)
            @(posedge i_clk);
        send_hold = 1'b0;

        send_idle_pct = 45;
        recv_idle_pct = 25;
        queue_random(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200);
        wait_drained();

        while (expected_matrices.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #800000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
